// ===== hw/rtl/sdotf_pkg.sv =====
// shared types, codes and constants of the sdo transfer framer
`timescale 1ns / 1ps

package sdotf_pkg;

    // cob-id bases and frame constants
    localparam logic [10:0] CLIENT_BASE     = 11'h600;
    localparam logic [10:0] SERVER_BASE     = 11'h580;
    localparam int          SEG_MAX         = 7;
    localparam int          EXP_MAX         = 4;
    localparam logic [3:0]  FRAME_LEN       = 4'd8;
    localparam logic [2:0]  CLIENT_INIT_CMD = 3'd1;
    localparam logic [2:0]  SERVER_INIT_CMD = 3'd2;
    localparam logic [7:0]  ABORT_CMD_BYTE  = 8'h80;
    localparam int          QUEUE_DEPTH_DEF = 2;

    // request codes
    localparam logic [1:0] REQ_START     = 2'd0;
    localparam logic [1:0] REQ_DATA      = 2'd1;
    localparam logic [1:0] REQ_EXPEDITED = 2'd2;
    localparam logic [1:0] REQ_ABORT     = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_COUNT   = 2'd1;
    localparam logic [1:0] ST_NO_TRANSFER = 2'd2;

    // register word addresses (paddr bit 2)
    localparam logic REG_NODE_ID     = 1'b0;
    localparam logic REG_SERVER_SIDE = 1'b1;

    // work kinds handed from front to back
    typedef enum logic [2:0] {
        KIND_START   = 3'd0,
        KIND_DATA    = 3'd1,
        KIND_FRAME   = 3'd2,
        KIND_ABORT   = 3'd3,
        KIND_EXP_ERR = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] frame;
        logic [7:0]  data;
    } entry_t;

    typedef struct packed {
        logic [6:0] node_id;
        logic       server_side;
    } cfg_t;

endpackage

// ===== hw/rtl/sdotf_queue.sv =====
// small fifo between the classifying front and the framing back
`timescale 1ns / 1ps

module sdotf_queue
    import sdotf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_valid,
    output logic   wr_ready,
    input  entry_t wr_data,
    output logic   rd_valid,
    input  logic   rd_ready,
    output entry_t rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/sdotf_front.sv =====
// register port and request classifier: turns each request into a queued work entry
`timescale 1ns / 1ps

module sdotf_front
    import sdotf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic [1:0]  req_type,
    input  logic [15:0] obj_index,
    input  logic [7:0]  obj_subindex,
    input  logic [31:0] word_value,
    input  logic [2:0]  expedited_count,
    input  logic [7:0]  payload_byte,
    output entry_t      entry,
    output cfg_t        cfg
);

    logic [6:0]  node_id_reg;
    logic        server_side_reg;
    logic        cfg_wr;
    logic [2:0]  init_cmd;
    logic [1:0]  exp_unused;
    logic [55:0] header_tail;
    logic        exp_bad;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg    = '{node_id: node_id_reg, server_side: server_side_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg     <= 7'd1;
            server_side_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_NODE_ID:     node_id_reg     <= pwdata[6:0];
                REG_SERVER_SIDE: server_side_reg <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[2])
            REG_NODE_ID:     prdata = {25'd0, node_id_reg};
            REG_SERVER_SIDE: prdata = {31'd0, server_side_reg};
            default:         prdata = '0;
        endcase
    end

    // header fields of start, expedited and abort frames; only the object tail goes into all three
    assign init_cmd    = server_side_reg ? SERVER_INIT_CMD : CLIENT_INIT_CMD;
    assign exp_unused  = 2'(3'(EXP_MAX) - expedited_count);
    assign header_tail = {word_value, obj_subindex, obj_index};
    assign exp_bad     = (expedited_count == 3'd0) || (expedited_count > 3'(EXP_MAX));

    // request decode
    always_comb
    begin
        entry.data  = payload_byte;
        entry.frame = '0;
        entry.kind  = KIND_DATA;
        unique case (req_type)
            REQ_START:
            begin
                entry.kind  = KIND_START;
                entry.frame = {header_tail, init_cmd, 5'b00001};
            end
            REQ_DATA:
            begin
                entry.kind = KIND_DATA;
            end
            REQ_EXPEDITED:
            begin
                entry.kind  = exp_bad ? KIND_EXP_ERR : KIND_FRAME;
                entry.frame = {header_tail, init_cmd, 1'b0, exp_unused, 2'b11};
            end
            REQ_ABORT:
            begin
                entry.kind  = KIND_ABORT;
                entry.frame = {header_tail, ABORT_CMD_BYTE};
            end
            default:
            begin
                entry.kind = KIND_DATA;
            end
        endcase
    end

endmodule

// ===== hw/rtl/sdotf_back.sv =====
// segment engine and result register: runs transfer state and builds frames
`timescale 1ns / 1ps

module sdotf_back
    import sdotf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    output logic        q_ready,
    input  entry_t      q_data,
    output logic        frame_valid,
    input  logic        frame_ready,
    output logic [10:0] cob_id,
    output logic [3:0]  frame_len,
    output logic [63:0] frame_bytes,
    output logic        final_frame,
    output logic [1:0]  status
);

    // transfer state
    logic        active_reg, active_next;
    logic        toggle_reg, toggle_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [2:0]  fill_reg, fill_next;
    logic [7:0]  buf_reg [SEG_MAX];
    logic        buf_we;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [10:0] cob_reg;
    logic [3:0]  len_reg;
    logic [63:0] bytes_reg;
    logic        fin_reg;
    logic [1:0]  status_reg;

    // result of the current entry
    logic        res_valid;
    logic [10:0] res_cob;
    logic [3:0]  res_len;
    logic [63:0] res_bytes;
    logic        res_fin;
    logic [1:0]  res_status;

    logic        load;
    logic [10:0] side_cob;
    logic [3:0]  new_fill;
    logic [31:0] bl_dec;
    logic        flush;
    logic        seg_last;
    logic [2:0]  seg_unused;
    logic [55:0] seg_data;

    assign load     = q_valid && (!out_valid_reg || frame_ready);
    assign q_ready  = load;
    assign side_cob = (cfg.server_side ? SERVER_BASE : CLIENT_BASE) + {4'd0, cfg.node_id};

    // segment fill bookkeeping
    assign new_fill   = {1'b0, fill_reg} + 4'd1;
    assign bl_dec     = bytes_left_reg - 32'd1;
    assign seg_last   = (bl_dec == 32'd0);
    assign flush      = (new_fill == 4'(SEG_MAX)) || seg_last;
    assign seg_unused = 3'(4'(SEG_MAX) - new_fill);

    // gather stored bytes plus the incoming one, zero past the fill point
    always_comb
    begin
        for (int i = 0; i < SEG_MAX; i++)
        begin
            if (3'(i) < fill_reg)
            begin
                seg_data[8*i +: 8] = buf_reg[i];
            end
            else if (3'(i) == fill_reg)
            begin
                seg_data[8*i +: 8] = q_data.data;
            end
            else
            begin
                seg_data[8*i +: 8] = 8'd0;
            end
        end
    end

    // per-kind action
    always_comb
    begin
        active_next     = active_reg;
        toggle_next     = toggle_reg;
        bytes_left_next = bytes_left_reg;
        fill_next       = fill_reg;
        buf_we          = 1'b0;
        res_valid       = 1'b1;
        res_cob         = side_cob;
        res_len         = FRAME_LEN;
        res_bytes       = q_data.frame;
        res_fin         = 1'b1;
        res_status      = ST_OK;
        unique case (q_data.kind)
            KIND_START:
            begin
                active_next     = (q_data.frame[63:32] != 32'd0);
                toggle_next     = 1'b0;
                bytes_left_next = q_data.frame[63:32];
                fill_next       = 3'd0;
                res_fin         = (q_data.frame[63:32] == 32'd0);
            end
            KIND_DATA:
            begin
                if (!active_reg)
                begin
                    res_cob    = '0;
                    res_len    = '0;
                    res_bytes  = '0;
                    res_fin    = 1'b0;
                    res_status = ST_NO_TRANSFER;
                end
                else if (!flush)
                begin
                    buf_we          = 1'b1;
                    fill_next       = new_fill[2:0];
                    bytes_left_next = bl_dec;
                    res_valid       = 1'b0;
                end
                else
                begin
                    res_bytes       = {seg_data, 3'b000, toggle_reg, seg_unused, seg_last};
                    res_fin         = seg_last;
                    fill_next       = 3'd0;
                    bytes_left_next = bl_dec;
                    toggle_next     = seg_last ? 1'b0 : !toggle_reg;
                    active_next     = !seg_last;
                end
            end
            KIND_FRAME:
            begin
                res_fin = 1'b1;
            end
            KIND_ABORT:
            begin
                active_next     = 1'b0;
                toggle_next     = 1'b0;
                bytes_left_next = '0;
                fill_next       = 3'd0;
            end
            KIND_EXP_ERR:
            begin
                res_cob    = '0;
                res_len    = '0;
                res_bytes  = '0;
                res_fin    = 1'b0;
                res_status = ST_BAD_COUNT;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // result valid: a taken result clears, a loaded entry may set
    always_comb
    begin
        if (load)
        begin
            out_valid_next = res_valid;
        end
        else
        begin
            out_valid_next = out_valid_reg && !frame_ready;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            toggle_reg     <= 1'b0;
            bytes_left_reg <= '0;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                active_reg     <= active_next;
                toggle_reg     <= toggle_next;
                bytes_left_reg <= bytes_left_next;
                fill_reg       <= fill_next;
            end
        end
    end

    // segment buffer and result payload
    always_ff @(posedge clk)
    begin
        if (load && buf_we)
        begin
            buf_reg[fill_reg] <= q_data.data;
        end
        if (load && res_valid)
        begin
            cob_reg    <= res_cob;
            len_reg    <= res_len;
            bytes_reg  <= res_bytes;
            fin_reg    <= res_fin;
            status_reg <= res_status;
        end
    end

    assign frame_valid = out_valid_reg;
    assign cob_id      = cob_reg;
    assign frame_len   = len_reg;
    assign frame_bytes = bytes_reg;
    assign final_frame = fin_reg;
    assign status      = status_reg;

endmodule

// ===== hw/rtl/sdo_transfer_framer.sv =====
// top level of the sdo transfer framer: front classifier, work queue, segment back end
// the request is written to the work queue, and the result register loads from the queue
// once the back end takes the entry; the result can then be taken while frame_valid is high
// throughput: one request per cycle while the result side does not stall
// data bytes that only fill a segment buffer give no result
// the queue absorbs stalls of the result side, the result register parts the sides
// reset: asynchronous active low, node 1, client side, no transfer, queue empty
`timescale 1ns / 1ps

module sdo_transfer_framer
    import sdotf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] obj_index,
    input  logic [7:0]  obj_subindex,
    input  logic [31:0] word_value,
    input  logic [2:0]  expedited_count,
    input  logic [7:0]  payload_byte,
    output logic        frame_valid,
    input  logic        frame_ready,
    output logic [10:0] cob_id,
    output logic [3:0]  frame_len,
    output logic [63:0] frame_bytes,
    output logic        final_frame,
    output logic [1:0]  status
);

    entry_t front_entry;
    entry_t q_entry;
    cfg_t   cfg;
    logic   q_valid;
    logic   q_ready;

    // request classification and register port
    sdotf_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .req_type        (req_type),
        .obj_index       (obj_index),
        .obj_subindex    (obj_subindex),
        .word_value      (word_value),
        .expedited_count (expedited_count),
        .payload_byte    (payload_byte),
        .entry           (front_entry),
        .cfg             (cfg)
    );

    // work queue
    sdotf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (req_valid),
        .wr_ready (req_ready),
        .wr_data  (front_entry),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_entry)
    );

    // segment engine and result register
    sdotf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_entry),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .cob_id      (cob_id),
        .frame_len   (frame_len),
        .frame_bytes (frame_bytes),
        .final_frame (final_frame),
        .status      (status)
    );

endmodule

// ===== hw/rtl/sdotf_checker.sv =====
// port-level checks of the sdo transfer framer, bound to the top level
`timescale 1ns / 1ps

module sdotf_checker
    import sdotf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        frame_valid,
    input logic        frame_ready,
    input logic [10:0] cob_id,
    input logic [3:0]  frame_len,
    input logic [63:0] frame_bytes,
    input logic        final_frame,
    input logic [1:0]  status
);

    // a stalled result transfer holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> frame_valid && $stable(frame_bytes)
            && $stable(cob_id) && $stable(status))
        else $error("result changed while stalled");

    // error results carry an empty frame
    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && (status != ST_OK) |-> (frame_len == 4'd0) && (cob_id == 11'd0)
            && (frame_bytes == 64'd0) && !final_frame)
        else $error("error result with frame content");

    // good results are full frames
    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && (status == ST_OK) |-> (frame_len == FRAME_LEN))
        else $error("good result with wrong length");

    // only defined status codes leave the block
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> (status == ST_OK) || (status == ST_BAD_COUNT)
            || (status == ST_NO_TRANSFER))
        else $error("undefined status code");

    // register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("register port stalled");

endmodule

bind sdo_transfer_framer sdotf_checker u_sdotf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pready      (pready),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .cob_id      (cob_id),
    .frame_len   (frame_len),
    .frame_bytes (frame_bytes),
    .final_frame (final_frame),
    .status      (status)
);
